/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* src/hnnc_pkg.sv */
// ----------------------------------------------------------------------------
// HSV nearest neighbour classifier package
// Field widths, command and status codes and shared record types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hnnc_pkg;

   localparam int HUE_W  = 14;
   localparam int SAT_W  = 15;
   localparam int VAL_W  = 16;
   localparam int LBL_W  = 3;
   localparam int DIST_W = 34;
   localparam int STAT_W = 2;

   localparam int HSQ_W = 2 * HUE_W;
   localparam int SSQ_W = 2 * SAT_W;
   localparam int VSQ_W = 2 * VAL_W;

   // Half a hue turn; a hue difference beyond it is taken the other way round.
   localparam logic [HUE_W-1:0] HUE_HALF = HUE_W'(8192);

   localparam logic [LBL_W-1:0] DEFAULT_LABEL_RST = LBL_W'(6);

   typedef enum logic {
      CMD_ADD      = 1'b0,
      CMD_CLASSIFY = 1'b1
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_CLASSIFIED = 2'd0,
      ST_ADDED      = 2'd1,
      ST_DROPPED    = 2'd2,
      ST_EMPTY      = 2'd3
   } status_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] sat;
      logic [VAL_W-1:0] val;
   } query_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] sat;
      logic [VAL_W-1:0] val;
      logic [LBL_W-1:0] label;
   } entry_type;

   // Travels beside each entry through the distance pipeline.
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [LBL_W-1:0] label;
   } tag_type;

endpackage

/* src/hnnc_if.sv */
// ----------------------------------------------------------------------------
// HSV nearest neighbour classifier channels
// Valid/ready channels for the request and the response beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hnnc_req_if import hnnc_pkg::*; ();
   logic             valid;
   logic             ready;
   cmd_type          cmd;
   logic [HUE_W-1:0] hue;
   logic [SAT_W-1:0] sat;
   logic [VAL_W-1:0] val;
   logic [LBL_W-1:0] train_label;

   modport source (output valid, cmd, hue, sat, val, train_label, input ready);
   modport sink   (input valid, cmd, hue, sat, val, train_label, output ready);
endinterface

interface hnnc_rsp_if import hnnc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LBL_W-1:0]  class_label;
   logic [DIST_W-1:0] best_dist_sq;
   status_type        status;

   modport source (output valid, class_label, best_dist_sq, status, input ready);
   modport sink   (input valid, class_label, best_dist_sq, status, output ready);
endinterface

/* src/hnnc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hnnc_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/hnnc_dist.sv */
// ----------------------------------------------------------------------------
// Squared HSV distance pipeline
// Three stages: folded absolute differences, squares, sum of squares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hnnc_dist import hnnc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  query_type         query,
   input  entry_type         entry,
   input  tag_type           tag_i,
   output logic [DIST_W-1:0] sq_dist,
   output tag_type           tag_o
);

   logic [HUE_W-1:0]  d_hue_in, d_hue_ff, hue_abs;
   logic [SAT_W-1:0]  d_sat_in, d_sat_ff;
   logic [VAL_W-1:0]  d_val_in, d_val_ff;
   logic [HSQ_W-1:0]  sq_hue_ff;
   logic [SSQ_W-1:0]  sq_sat_ff;
   logic [VSQ_W-1:0]  sq_val_ff;
   logic [DIST_W-1:0] sum_ff;
   tag_type           tag1_ff, tag2_ff, tag3_ff;

   always_comb begin
      hue_abs  = (entry.hue > query.hue) ? entry.hue - query.hue : query.hue - entry.hue;
      // Negating in hue width gives one full turn minus the difference.
      d_hue_in = (hue_abs > HUE_HALF) ? HUE_W'(0) - hue_abs : hue_abs;
      d_sat_in = (entry.sat > query.sat) ? entry.sat - query.sat : query.sat - entry.sat;
      d_val_in = (entry.val > query.val) ? entry.val - query.val : query.val - entry.val;
   end

   always_ff @(posedge clock) begin
      d_hue_ff  <= d_hue_in;
      d_sat_ff  <= d_sat_in;
      d_val_ff  <= d_val_in;
      sq_hue_ff <= HSQ_W'(d_hue_ff) * HSQ_W'(d_hue_ff);
      sq_sat_ff <= SSQ_W'(d_sat_ff) * SSQ_W'(d_sat_ff);
      sq_val_ff <= VSQ_W'(d_val_ff) * VSQ_W'(d_val_ff);
      sum_ff    <= DIST_W'(sq_hue_ff) + DIST_W'(sq_sat_ff) + DIST_W'(sq_val_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
      end else begin
         tag1_ff <= tag_i;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   assign sq_dist = sum_ff;
   assign tag_o   = tag3_ff;

endmodule

/* src/hsv_nearest_neighbour_classifier_unit.sv */
// ----------------------------------------------------------------------------
// HSV nearest neighbour classifier unit
// Keeps up to MAX_ENTRIES labelled HSV training points in an on-chip RAM and
// answers each classify beat with the label of the nearest stored point and
// its squared distance, hue taken round the circle. A classify beat scans the
// stored entries through the single RAM read port, one entry per cycle,
// through the registered read and the three-stage distance pipeline, and
// then hands off the result. A classify on an empty store returns the
// default label without a scan. The next request beat is taken while a
// response still waits to be taken. The store needs no clearing after
// reset, and configuration writes are expected only while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsv_nearest_neighbour_classifier_unit import hnnc_pkg::*; #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [LBL_W-1:0] csr_wr_data,
   hnnc_req_if.sink         req_chan,
   hnnc_rsp_if.source       rsp_chan
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [LBL_W-1:0]  default_label_ff;
   query_type         query_ff, query_in;
   logic [AW-1:0]     scan_idx_ff, scan_idx_in;
   logic              iss_valid_ff, iss_valid_in;
   logic              iss_last_ff, iss_last_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [LBL_W-1:0]  best_lbl_ff, best_lbl_in;
   logic              best_valid_ff, best_valid_in;
   logic [LBL_W-1:0]  res_lbl_ff, res_lbl_in;
   logic [DIST_W-1:0] res_dist_ff, res_dist_in;
   status_type        res_stat_ff, res_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LBL_W-1:0]  rsp_lbl_ff, rsp_lbl_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   status_type        rsp_stat_ff, rsp_stat_in;

   logic              req_acc, full, ram_wr_en, ram_rd_en, take, scan_last, slot_free;
   entry_type         wr_entry, rd_entry;
   logic [EW-1:0]     rd_word;
   tag_type           tag_i, tag_o;
   logic [DIST_W-1:0] cand_dist;

   assign req_acc   = req_chan.valid && req_chan.ready;
   assign full      = (count_ff == CW'(MAX_ENTRIES));
   assign scan_last = ((CW'(scan_idx_ff) + CW'(1)) == count_ff);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   assign wr_entry.hue   = req_chan.hue;
   assign wr_entry.sat   = req_chan.sat;
   assign wr_entry.val   = req_chan.val;
   assign wr_entry.label = req_chan.train_label;

   assign ram_wr_en = req_acc && (req_chan.cmd == CMD_ADD) && !full;
   assign ram_rd_en = (state_ff == S_SCAN);

   hnnc_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_word)
   );

   assign rd_entry    = entry_type'(rd_word);
   assign tag_i.valid = iss_valid_ff;
   assign tag_i.last  = iss_last_ff;
   assign tag_i.label = rd_entry.label;

   hnnc_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .query   (query_ff),
      .entry   (rd_entry),
      .tag_i   (tag_i),
      .sq_dist (cand_dist),
      .tag_o   (tag_o)
   );

   // Strict less-than keeps the earliest entry on a tie.
   assign take = tag_o.valid && (!best_valid_ff || (cand_dist < best_dist_ff));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      query_in      = query_ff;
      scan_idx_in   = scan_idx_ff;
      iss_valid_in  = 1'b0;
      iss_last_in   = 1'b0;
      best_dist_in  = take ? cand_dist : best_dist_ff;
      best_lbl_in   = take ? tag_o.label : best_lbl_ff;
      best_valid_in = best_valid_ff || tag_o.valid;
      res_lbl_in    = res_lbl_ff;
      res_dist_in   = res_dist_ff;
      res_stat_in   = res_stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_lbl_in    = rsp_lbl_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_stat_in   = rsp_stat_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               res_lbl_in  = '0;
               res_dist_in = '0;
               if (req_chan.cmd == CMD_ADD) begin
                  res_stat_in = full ? ST_DROPPED : ST_ADDED;
                  if (!full) begin
                     count_in = count_ff + CW'(1);
                  end
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  res_lbl_in  = default_label_ff;
                  res_stat_in = ST_EMPTY;
                  state_in    = S_DONE;
               end else begin
                  query_in.hue  = req_chan.hue;
                  query_in.sat  = req_chan.sat;
                  query_in.val  = req_chan.val;
                  scan_idx_in   = '0;
                  best_valid_in = 1'b0;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            iss_valid_in = 1'b1;
            iss_last_in  = scan_last;
            if (scan_last) begin
               state_in = S_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            if (tag_o.valid && tag_o.last) begin
               res_lbl_in  = best_lbl_in;
               res_dist_in = best_dist_in;
               res_stat_in = ST_CLASSIFIED;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_lbl_in   = res_lbl_ff;
               rsp_dist_in  = res_dist_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         count_ff         <= '0;
         default_label_ff <= DEFAULT_LABEL_RST;
         iss_valid_ff     <= 1'b0;
         best_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         iss_valid_ff  <= iss_valid_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            default_label_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      query_ff     <= query_in;
      scan_idx_ff  <= scan_idx_in;
      iss_last_ff  <= iss_last_in;
      best_dist_ff <= best_dist_in;
      best_lbl_ff  <= best_lbl_in;
      res_lbl_ff   <= res_lbl_in;
      res_dist_ff  <= res_dist_in;
      res_stat_ff  <= res_stat_in;
      rsp_lbl_ff   <= rsp_lbl_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.class_label  = rsp_lbl_ff;
   assign rsp_chan.best_dist_sq = rsp_dist_ff;
   assign rsp_chan.status       = rsp_stat_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(MAX_ENTRIES), "entry count above capacity")
   `ASSERT_IMPLIES(a_wr_only_idle, clock, reset, ram_wr_en, state_ff == S_IDLE, "store written outside idle")
   `ASSERT_IMPLIES(a_pipe_in_scan, clock, reset, tag_o.valid, state_ff == S_SCAN || state_ff == S_DRAIN, "distance beat outside a scan")
   `ASSERT_NEXT(a_add_counts, clock, reset, ram_wr_en, count_ff == $past(count_ff) + CW'(1), "add did not advance the count")

endmodule
